### sv/rol_pkg.sv
`default_nettype none

package rol_pkg;

  localparam int POS_W    = 32;
  localparam int MARGIN_W = 20;
  localparam int SUM_W    = POS_W + 2;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W = 8;

  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OVERLAP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EXTENDED = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POINT    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MARGIN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MARGIN = 8'd1;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CLEAR,
    KIND_APPEND,
    KIND_QUERY
  } kind_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  last_pos;
  } item_t;

  typedef struct packed {
    logic       found;
    logic [5:0] match_index;
    logic       rejected;
    logic [6:0] stored_count;
  } result_t;

  // beat traveling down the cell row; query bounds are pre-offset by the margins
  typedef struct packed {
    logic                    valid;
    kind_t                   kind;
    logic                    point;
    logic                    rejected;
    logic                    found;
    logic [POS_W-1:0]        reg_start;
    logic [POS_W-1:0]        reg_end;
    logic signed [SUM_W-1:0] qs_pl;   // first + left
    logic signed [SUM_W-1:0] qe_pl;   // last + left
    logic signed [SUM_W-1:0] qs_ml;   // first - left
    logic signed [SUM_W-1:0] qe_pr;   // last + right
    logic signed [SUM_W-1:0] qs_mr;   // first - right
    logic signed [SUM_W-1:0] qe_mr;   // last - right
  } tok_t;

endpackage

`default_nettype wire

### sv/rol_entry.sv
`default_nettype none

module rol_entry #(
  parameter int DEPTH = 64,
  parameter int CNTW  = 7
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire rol_pkg::item_t                    item,
  input  wire logic                              cfg_we,
  input  wire logic [rol_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rol_pkg::MARGIN_W-1:0]      cfg_data,
  output rol_pkg::tok_t                          tok,
  output logic [CNTW-1:0]                        cnt
);

  logic [CNTW-1:0]              count;
  logic [CNTW-1:0]              count_next;
  logic [rol_pkg::MARGIN_W-1:0] left_margin;
  logic [rol_pkg::MARGIN_W-1:0] right_margin;
  logic [rol_pkg::MARGIN_W-1:0] lm;
  logic [rol_pkg::MARGIN_W-1:0] rm;
  logic signed [rol_pkg::SUM_W-1:0] qs;
  logic signed [rol_pkg::SUM_W-1:0] qe;
  logic signed [rol_pkg::SUM_W-1:0] lm_s;
  logic signed [rol_pkg::SUM_W-1:0] rm_s;
  logic full;

  assign full = (count == CNTW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      left_margin  <= '0;
      right_margin <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rol_pkg::CFG_LEFT_MARGIN) begin
        left_margin <= cfg_data;
      end else if (cfg_index == rol_pkg::CFG_RIGHT_MARGIN) begin
        right_margin <= cfg_data;
      end
    end
  end

  always_comb begin
    lm   = (item.mode == rol_pkg::MODE_EXTENDED) ? left_margin  : '0;
    rm   = (item.mode == rol_pkg::MODE_EXTENDED) ? right_margin : '0;
    qs   = signed'({2'b00, item.first_pos});
    qe   = signed'({2'b00, item.last_pos});
    lm_s = signed'({{(rol_pkg::SUM_W - rol_pkg::MARGIN_W){1'b0}}, lm});
    rm_s = signed'({{(rol_pkg::SUM_W - rol_pkg::MARGIN_W){1'b0}}, rm});

    tok           = '0;
    tok.valid     = accept;
    tok.kind      = rol_pkg::KIND_NONE;
    tok.reg_start = item.first_pos;
    tok.reg_end   = item.last_pos;
    tok.point     = (item.mode == rol_pkg::MODE_POINT);
    tok.qs_pl     = qs + lm_s;
    tok.qe_pl     = qe + lm_s;
    tok.qs_ml     = qs - lm_s;
    tok.qe_pr     = qe + rm_s;
    tok.qs_mr     = qs - rm_s;
    tok.qe_mr     = qe - rm_s;
    count_next    = count;

    unique case (item.mode)
      rol_pkg::MODE_CLEAR: begin
        tok.kind   = rol_pkg::KIND_CLEAR;
        count_next = '0;
      end
      rol_pkg::MODE_APPEND: begin
        tok.kind = rol_pkg::KIND_APPEND;
        if (full) begin
          tok.rejected = 1'b1;
        end else begin
          count_next = count + CNTW'(1);
        end
      end
      rol_pkg::MODE_OVERLAP, rol_pkg::MODE_EXTENDED, rol_pkg::MODE_POINT: begin
        tok.kind = rol_pkg::KIND_QUERY;
      end
      default: begin
        tok.kind = rol_pkg::KIND_NONE;
      end
    endcase
    cnt = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH))
    else $error("region count above table depth");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && item.mode == rol_pkg::MODE_CLEAR |=> count == '0)
    else $error("clear did not empty the table");

  a_append: assert property (@(posedge clk) disable iff (rst)
    accept && item.mode == rol_pkg::MODE_APPEND && !full |=>
      count == $past(count) + CNTW'(1))
    else $error("append did not bump the count");

endmodule

`default_nettype wire

### sv/rol_cell.sv
`default_nettype none

module rol_cell #(
  parameter int INDEX = 0,
  parameter int IDXW  = 6,
  parameter int CNTW  = 7
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire rol_pkg::tok_t   tok_in,
  input  wire logic [CNTW-1:0] cnt_in,
  input  wire logic [IDXW-1:0] idx_in,
  output rol_pkg::tok_t        tok_out,
  output logic [CNTW-1:0]      cnt_out,
  output logic [IDXW-1:0]      idx_out
);

  logic                    rvalid;
  logic [rol_pkg::POS_W-1:0] rs;
  logic [rol_pkg::POS_W-1:0] re;
  logic signed [rol_pkg::SUM_W-1:0] rs_s;
  logic signed [rol_pkg::SUM_W-1:0] re_s;
  logic t1, t2, t3, t4, hit, take;
  rol_pkg::tok_t   tok_next;
  logic [IDXW-1:0] idx_next;

  always_comb begin
    rs_s = signed'({2'b00, rs});
    re_s = signed'({2'b00, re});
    t1 = (tok_in.qs_pl >= rs_s) && (tok_in.qs_mr <= re_s);
    t2 = (tok_in.qe_pl >= rs_s) && (tok_in.qe_mr <= re_s);
    t3 = (rs_s >= tok_in.qs_ml) && (rs_s <= tok_in.qe_pr);
    t4 = (re_s >= tok_in.qs_ml) && (re_s <= tok_in.qe_pr);
    // a point query only uses the containment term
    hit = rvalid && (t1 || (!tok_in.point && (t2 || t3 || t4)));
    // this cell is the slot the append was counted into
    take = (tok_in.kind == rol_pkg::KIND_APPEND) && !tok_in.rejected &&
           (cnt_in == CNTW'(INDEX + 1));

    tok_next = tok_in;
    idx_next = idx_in;
    if (tok_in.kind == rol_pkg::KIND_QUERY && !tok_in.found && hit) begin
      tok_next.found = 1'b1;
      idx_next       = IDXW'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid        <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
      cnt_out <= cnt_in;
      idx_out <= idx_next;
      if (tok_in.valid && tok_in.kind == rol_pkg::KIND_CLEAR) begin
        rvalid <= 1'b0;
      end else if (tok_in.valid && take) begin
        rvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok_in.valid && take) begin
      rs <= tok_in.reg_start;
      re <= tok_in.reg_end;
    end
  end

endmodule

`default_nettype wire

### sv/region_overlap_lookup_table_top.sv
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+--------------------------------
// item     | in        | item_valid / item_stall    | mode, first_pos, last_pos
// result   | out       | result_valid / result_stall| found, match_index, rejected,
//          |           |                            | stored_count
// cfg      | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// each beat walks a row of TABLE_DEPTH cells, one cell per cycle while the row advances, one region per cell.
// a new item can enter every cycle unless the row is stalled; each cell registers the beat on its way through.
// sync reset empties the table and zeroes both margins; no clearing pass is needed.
// a stalled valid result freezes the whole row and raises item_stall.
// cfg_ready is always high.
`default_nettype none

module region_overlap_lookup_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire rol_pkg::item_t                    item,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output rol_pkg::result_t                       result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rol_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rol_pkg::MARGIN_W-1:0]      cfg_data
);

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);

  rol_pkg::tok_t   chain_tok [TABLE_DEPTH+1];
  logic [CNTW-1:0] chain_cnt [TABLE_DEPTH+1];
  logic [IDXW-1:0] chain_idx [TABLE_DEPTH+1];
  logic advance;
  logic accept;

  assign advance    = !(chain_tok[TABLE_DEPTH].valid && result_stall);
  assign item_stall = !advance;
  assign accept     = item_valid && advance;
  assign cfg_ready  = 1'b1;

  rol_entry #(
    .DEPTH(TABLE_DEPTH),
    .CNTW (CNTW)
  ) u_entry (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .tok      (chain_tok[0]),
    .cnt      (chain_cnt[0])
  );

  assign chain_idx[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rol_cell #(
      .INDEX(i),
      .IDXW (IDXW),
      .CNTW (CNTW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .advance(advance),
      .tok_in (chain_tok[i]),
      .cnt_in (chain_cnt[i]),
      .idx_in (chain_idx[i]),
      .tok_out(chain_tok[i+1]),
      .cnt_out(chain_cnt[i+1]),
      .idx_out(chain_idx[i+1])
    );
  end

  always_comb begin
    result_valid        = chain_tok[TABLE_DEPTH].valid;
    result.found        = chain_tok[TABLE_DEPTH].found;
    result.match_index  = 6'(chain_idx[TABLE_DEPTH]);
    result.rejected     = chain_tok[TABLE_DEPTH].rejected;
    result.stored_count = 7'(chain_cnt[TABLE_DEPTH]);
  end

endmodule

`default_nettype wire

### verif/region_overlap_lookup_table_checker.sv
`timescale 1ns / 100ps

module region_overlap_lookup_table_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  rol_pkg::item_t                item,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  rol_pkg::result_t              result,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rol_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rol_pkg::MARGIN_W-1:0]  cfg_data,
  output int                            mismatches,
  output int                            outstanding,
  output int                            rejects_seen
);

  logic [rol_pkg::POS_W-1:0]    table_start [TABLE_DEPTH];
  logic [rol_pkg::POS_W-1:0]    table_end   [TABLE_DEPTH];
  int                           table_fill;
  logic [rol_pkg::MARGIN_W-1:0] left_ext;
  logic [rol_pkg::MARGIN_W-1:0] right_ext;
  rol_pkg::result_t             lookup_q [$];
  int                           err_total;
  int                           reject_total;

  // sums are SUM_W wide so the margin terms never wrap
  function automatic logic intervals_meet(
      logic [rol_pkg::SUM_W-1:0] qs, logic [rol_pkg::SUM_W-1:0] qe,
      logic [rol_pkg::SUM_W-1:0] rs, logic [rol_pkg::SUM_W-1:0] re,
      logic [rol_pkg::SUM_W-1:0] lm, logic [rol_pkg::SUM_W-1:0] rm);
    return (qs + lm >= rs && qs <= re + rm) ||
           (qe + lm >= rs && qe <= re + rm) ||
           (rs + lm >= qs && rs <= qe + rm) ||
           (re + lm >= qs && re <= qe + rm);
  endfunction

  function automatic rol_pkg::result_t apply_item(rol_pkg::item_t it);
    rol_pkg::result_t          res;
    logic [rol_pkg::SUM_W-1:0] lm;
    logic [rol_pkg::SUM_W-1:0] rm;
    logic                      hit;
    res = '0;
    lm  = '0;
    rm  = '0;
    if (it.mode == rol_pkg::MODE_EXTENDED) begin
      lm = rol_pkg::SUM_W'(left_ext);
      rm = rol_pkg::SUM_W'(right_ext);
    end
    case (it.mode)
      rol_pkg::MODE_CLEAR: table_fill = 0;
      rol_pkg::MODE_APPEND: begin
        if (table_fill < TABLE_DEPTH) begin
          table_start[table_fill] = it.first_pos;
          table_end[table_fill]   = it.last_pos;
          table_fill++;
        end else begin
          res.rejected = 1'b1;
        end
      end
      rol_pkg::MODE_OVERLAP, rol_pkg::MODE_EXTENDED, rol_pkg::MODE_POINT: begin
        for (int i = 0; i < table_fill; i++) begin
          if (it.mode == rol_pkg::MODE_POINT)
            hit = it.first_pos >= table_start[i] && it.first_pos <= table_end[i];
          else
            hit = intervals_meet(rol_pkg::SUM_W'(it.first_pos), rol_pkg::SUM_W'(it.last_pos),
                                 rol_pkg::SUM_W'(table_start[i]),
                                 rol_pkg::SUM_W'(table_end[i]), lm, rm);
          // lowest matching index wins
          if (hit && !res.found) begin
            res.found       = 1'b1;
            res.match_index = 6'(i);
          end
        end
      end
      default: ;
    endcase
    res.stored_count = 7'(table_fill);
    return res;
  endfunction

  function automatic int field_differs(string name, logic [6:0] want_v, logic [6:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    rol_pkg::result_t want;
    if (rst) begin
      table_fill   = 0;
      left_ext     = '0;
      right_ext    = '0;
      err_total    = 0;
      reject_total = 0;
      lookup_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rol_pkg::CFG_LEFT_MARGIN:  left_ext  = cfg_data;
          rol_pkg::CFG_RIGHT_MARGIN: right_ext = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall)
        lookup_q = {lookup_q, apply_item(item)};
      if (result_valid && !result_stall) begin
        if (lookup_q.size() == 0) begin
          $error("result beat arrived with nothing expected");
          err_total++;
        end else begin
          want = lookup_q.pop_front();
          if (want.rejected)
            reject_total++;
          err_total += field_differs("found", 7'(want.found), 7'(result.found));
          err_total += field_differs("match_index", 7'(want.match_index),
                                     7'(result.match_index));
          err_total += field_differs("rejected", 7'(want.rejected), 7'(result.rejected));
          err_total += field_differs("stored_count", want.stored_count, result.stored_count);
        end
      end
    end
    mismatches   <= err_total;
    rejects_seen <= reject_total;
    outstanding  <= lookup_q.size();
  end

endmodule

### verif/region_overlap_lookup_table_top_test.sv
`timescale 1ns / 100ps

module region_overlap_lookup_table_top_test;

  localparam int TABLE_DEPTH  = 64;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int PHASE_ITEMS  = 305;
  localparam int PHASES       = 6;

  localparam logic [rol_pkg::MODE_W-1:0]    MODE_SPARE_FIRST = 3'd5;
  localparam logic [rol_pkg::MODE_W-1:0]    MODE_SPARE_LAST  = 3'd7;
  localparam logic [rol_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST  =
    rol_pkg::CFG_RIGHT_MARGIN + 8'd1;
  localparam logic [rol_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST   = '1;
  localparam logic [rol_pkg::MARGIN_W-1:0]  MARGIN_MAX       = '1;
  localparam logic [rol_pkg::POS_W-1:0]     POS_MAX          = '1;

  logic                          clk;
  logic                          rst;
  logic                          item_valid;
  logic                          item_stall;
  rol_pkg::item_t                item;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  rol_pkg::result_t              result;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rol_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rol_pkg::MARGIN_W-1:0]  cfg_data;

  int   mismatches;
  int   outstanding;
  int   rejects_seen;
  logic idle_on = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   items_sent = 0;
  int   mode_tally [8];
  int   cfg_writes = 0;

  logic [rol_pkg::POS_W-1:0] cluster_base;
  logic [rol_pkg::POS_W-1:0] known_lo [$];
  logic [rol_pkg::POS_W-1:0] known_hi [$];

  region_overlap_lookup_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  region_overlap_lookup_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) lookup_check (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .rejects_seen(rejects_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side backpressure in random bursts
  always @(posedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 16);
    result_stall <= stall_left > 0;
    if (stall_left > 0)
      stall_left--;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic [rol_pkg::MODE_W-1:0] mode,
                           input logic [rol_pkg::POS_W-1:0] first_pos,
                           input logic [rol_pkg::POS_W-1:0] last_pos);
    rol_pkg::item_t beat;
    beat.mode      = mode;
    beat.first_pos = first_pos;
    beat.last_pos  = last_pos;
    if (idle_on && $urandom_range(0, 11) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    @(negedge clk);
    while (item_stall) @(negedge clk);
    @(posedge clk);
    if (mode <= rol_pkg::MODE_POINT)
      items_sent++;
    mode_tally[mode]++;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(negedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [rol_pkg::CFG_IDX_W-1:0] index,
                           input logic [rol_pkg::MARGIN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic set_margins(input logic [rol_pkg::MARGIN_W-1:0] lm,
                             input logic [rol_pkg::MARGIN_W-1:0] rm);
    wait_idle();
    write_reg(rol_pkg::CFG_LEFT_MARGIN, lm);
    write_reg(rol_pkg::CFG_RIGHT_MARGIN, rm);
    // unmapped index must leave both margins alone
    write_reg(rol_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
              rol_pkg::MARGIN_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [rol_pkg::POS_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return rol_pkg::POS_W'($urandom_range(0, 2047));
      2:       return POS_MAX - rol_pkg::POS_W'($urandom_range(0, 2047));
      default: return cluster_base + rol_pkg::POS_W'($urandom_range(0, 8191));
    endcase
  endfunction

  task automatic clear_table();
    send_beat(rol_pkg::MODE_CLEAR, $urandom(), $urandom());
    known_lo.delete();
    known_hi.delete();
    if ($urandom_range(0, 3) == 0)
      cluster_base = $urandom();
  endtask

  task automatic append_region();
    logic [rol_pkg::POS_W-1:0] lo;
    logic [rol_pkg::POS_W-1:0] hi;
    lo = pick_pos();
    case ($urandom_range(0, 9))
      0:       hi = $urandom();
      1:       hi = lo - rol_pkg::POS_W'($urandom_range(1, 500));
      default: hi = lo + rol_pkg::POS_W'($urandom_range(0, 600));
    endcase
    send_beat(rol_pkg::MODE_APPEND, lo, hi);
    if (known_lo.size() < TABLE_DEPTH) begin
      known_lo = {known_lo, lo};
      known_hi = {known_hi, hi};
    end
  endtask

  task automatic query_table();
    logic [rol_pkg::MODE_W-1:0] mode;
    logic [rol_pkg::POS_W-1:0]  qs;
    logic [rol_pkg::POS_W-1:0]  qe;
    logic [rol_pkg::POS_W-1:0]  anchor;
    int                         pick;
    case ($urandom_range(0, 2))
      0:       mode = rol_pkg::MODE_OVERLAP;
      1:       mode = rol_pkg::MODE_EXTENDED;
      default: mode = rol_pkg::MODE_POINT;
    endcase
    if (known_lo.size() > 0 && $urandom_range(0, 1) == 1) begin
      // aim near a stored region edge so hits and near misses both show up
      pick   = $urandom_range(0, known_lo.size() - 1);
      anchor = $urandom_range(0, 1) ? known_lo[pick] : known_hi[pick];
      if (mode == rol_pkg::MODE_POINT)
        qs = anchor - 32'd4 + rol_pkg::POS_W'($urandom_range(0, 8));
      else
        qs = anchor - 32'd600 + rol_pkg::POS_W'($urandom_range(0, 1200));
      qe = qs + rol_pkg::POS_W'($urandom_range(0, 800));
    end else begin
      qs = pick_pos();
      qe = $urandom_range(0, 3) == 0 ? pick_pos() :
           qs + rol_pkg::POS_W'($urandom_range(0, 5000));
    end
    if ($urandom_range(0, 9) == 0)
      send_beat(mode, qe, qs);
    else
      send_beat(mode, qs, qe);
  endtask

  task automatic send_noise();
    send_beat(rol_pkg::MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
              $urandom(), $urandom());
  endtask

  task automatic run_episode();
    int appends;
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 4)) send_noise();
      return;
    end
    if ($urandom_range(0, 2) == 0)
      clear_table();
    // now and then overfill the table to hit the reject path
    appends = $urandom_range(0, 9) == 0 ? $urandom_range(60, 70) : $urandom_range(1, 10);
    repeat (appends) append_region();
    repeat ($urandom_range(4, 20)) begin
      if ($urandom_range(0, 15) == 0)
        append_region();
      else if ($urandom_range(0, 30) == 0)
        send_noise();
      else
        query_table();
    end
    if ($urandom_range(0, 19) == 0)
      wait_idle();
  endtask

  initial begin
    logic [rol_pkg::MARGIN_W-1:0] lm;
    logic [rol_pkg::MARGIN_W-1:0] rm;
    int                           target;
    foreach (mode_tally[m]) mode_tally[m] = 0;
    cluster_base = $urandom();
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, reversed bounds, unused modes
    send_beat(rol_pkg::MODE_OVERLAP, '0, POS_MAX);
    send_beat(rol_pkg::MODE_POINT, POS_MAX, '0);
    send_beat(MODE_SPARE_FIRST, POS_MAX, POS_MAX);
    send_beat(rol_pkg::MODE_APPEND, '0, '0);
    send_beat(rol_pkg::MODE_APPEND, POS_MAX, POS_MAX);
    send_beat(rol_pkg::MODE_APPEND, 32'd1000, 32'd10);
    send_beat(rol_pkg::MODE_APPEND, 32'd100, 32'd200);
    send_beat(rol_pkg::MODE_OVERLAP, '0, '0);
    send_beat(rol_pkg::MODE_OVERLAP, 32'd150, 32'd150);
    send_beat(rol_pkg::MODE_OVERLAP, POS_MAX, POS_MAX);
    send_beat(rol_pkg::MODE_OVERLAP, 32'd300, 32'd50);
    send_beat(rol_pkg::MODE_EXTENDED, 32'd201, 32'd300);
    send_beat(rol_pkg::MODE_POINT, '0, POS_MAX);
    send_beat(rol_pkg::MODE_POINT, POS_MAX, '0);
    send_beat(rol_pkg::MODE_POINT, 32'd150, '0);
    send_beat(rol_pkg::MODE_POINT, 32'd500, '0);
    send_beat(MODE_SPARE_LAST, '0, '0);
    set_margins(MARGIN_MAX, MARGIN_MAX);
    send_beat(rol_pkg::MODE_EXTENDED, 32'd201, 32'd300);
    send_beat(rol_pkg::MODE_EXTENDED, POS_MAX, POS_MAX);
    send_beat(rol_pkg::MODE_EXTENDED, 32'd5000000, 32'd6000000);
    send_beat(rol_pkg::MODE_CLEAR, POS_MAX, POS_MAX);
    send_beat(rol_pkg::MODE_OVERLAP, '0, POS_MAX);
    send_beat(rol_pkg::MODE_APPEND, 32'd7, 32'd7);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          lm = '0;
          rm = '0;
        end
        1: begin
          lm = MARGIN_MAX;
          rm = MARGIN_MAX;
        end
        2: begin
          lm = '0;
          rm = MARGIN_MAX;
        end
        3: begin
          lm = MARGIN_MAX;
          rm = '0;
        end
        4: begin
          lm = rol_pkg::MARGIN_W'($urandom_range(0, 2000));
          rm = rol_pkg::MARGIN_W'($urandom_range(0, 2000));
        end
        default: begin
          lm = rol_pkg::MARGIN_W'($urandom());
          rm = rol_pkg::MARGIN_W'($urandom());
        end
      endcase
      set_margins(lm, rm);
      // phase 2 runs without idling; the last phase too
      idle_on <= phase != 2 && phase < PHASES - 1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target)
        run_episode();
    end

    idle_on <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("items %0d: clear %0d, append %0d, overlap %0d, extended %0d, point %0d",
             items_sent, mode_tally[rol_pkg::MODE_CLEAR], mode_tally[rol_pkg::MODE_APPEND],
             mode_tally[rol_pkg::MODE_OVERLAP], mode_tally[rol_pkg::MODE_EXTENDED],
             mode_tally[rol_pkg::MODE_POINT]);
    $display("unused-mode beats %0d, register writes %0d, full-table rejects %0d, mismatches %0d",
             mode_tally[5] + mode_tally[6] + mode_tally[7], cfg_writes, rejects_seen, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
